FILE: hdl/wsl_pkg.sv
`default_nettype none
package wsl_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int DATA_W      = 32;
	localparam int DIFF_W      = DATA_W + 1;
	localparam int DIV_W       = 64;
	localparam int SLOPE_ITERS = DIFF_W + FRAC_BITS;
	localparam int COMB_ITERS  = 32;
	localparam int CNT_W       = 7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SINGLE,
		ST_SL_START,
		ST_SL_WAIT,
		ST_SL_FIN,
		ST_C_SQ,
		ST_C_CMP,
		ST_C_BRANCH,
		ST_C_MUL1,
		ST_C_MUL2,
		ST_C_DIV_START,
		ST_C_DIV_WAIT,
		ST_C_RES,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		OUT_SINGLE,
		OUT_LEFT,
		OUT_RIGHT
	} out_kind_t;

	typedef struct packed {
		logic      accept;
		logic      sl_div_start;
		logic      sl_fin;
		logic      second;
		logic      c_sq;
		logic      c_cmp;
		logic      c_mul1;
		logic      c_mul2;
		logic      c_div_start;
		logic      c_res;
		logic      out_load;
		out_kind_t out_kind;
		logic      commit;
		logic      clear;
	} cmd_t;

	typedef struct packed {
		logic have;
		logic cur_last;
		logic dx_zero;
		logic div_busy;
		logic do_divide;
		logic out_free;
	} sts_t;

	// signed saturation of an unsigned magnitude
	function automatic logic [DATA_W-1:0] sat_mag(input logic [DIV_W-1:0] q, input logic neg);
		logic [DIV_W-1:0] lim_neg;
		logic [DIV_W-1:0] lim_pos;
		logic [DATA_W-1:0] res;
		lim_neg = DIV_W'(64'h8000_0000);
		lim_pos = DIV_W'(64'h7fff_ffff);
		if (neg) begin
			if (q > lim_neg)
				res = {1'b1, {(DATA_W-1){1'b0}}};
			else
				res = DATA_W'(~q + DIV_W'(1));
		end else begin
			if (q > lim_pos)
				res = {1'b0, {(DATA_W-1){1'b1}}};
			else
				res = q[DATA_W-1:0];
		end
		return res;
	endfunction

	function automatic logic sat_hit(input logic [DIV_W-1:0] q, input logic neg);
		return neg ? (q > DIV_W'(64'h8000_0000)) : (q > DIV_W'(64'h7fff_ffff));
	endfunction

endpackage
`default_nettype wire

FILE: hdl/wsl_divider.sv
`default_nettype none
module wsl_divider (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [wsl_pkg::DIV_W-1:0]   rem_init,
	input  wire logic [wsl_pkg::DIV_W-1:0]   dividend,
	input  wire logic [wsl_pkg::DIV_W-1:0]   divisor,
	input  wire logic [wsl_pkg::CNT_W-1:0]   iters,
	output logic                             busy,
	output logic [wsl_pkg::DIV_W-1:0]        quotient
);

	logic [wsl_pkg::DIV_W-1:0] rem_q;
	logic [wsl_pkg::DIV_W-1:0] num_q;
	logic [wsl_pkg::DIV_W-1:0] den_q;
	logic [wsl_pkg::DIV_W-1:0] quot_q;
	logic [wsl_pkg::CNT_W-1:0] cnt_q;
	logic                      busy_q;
	logic [wsl_pkg::DIV_W:0]   r_sh;
	logic                      ge;
	logic [wsl_pkg::DIV_W:0]   r_sub;

	assign r_sh  = {rem_q, num_q[wsl_pkg::DIV_W-1]};
	assign ge    = r_sh >= {1'b0, den_q};
	assign r_sub = r_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= iters;
		end else if (busy_q) begin
			cnt_q <= cnt_q - wsl_pkg::CNT_W'(1);
			if (cnt_q == wsl_pkg::CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			num_q  <= dividend;
			den_q  <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? r_sub[wsl_pkg::DIV_W-1:0] : r_sh[wsl_pkg::DIV_W-1:0];
			num_q  <= {num_q[wsl_pkg::DIV_W-2:0], 1'b0};
			quot_q <= {quot_q[wsl_pkg::DIV_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quot_q;

endmodule
`default_nettype wire

FILE: hdl/wsl_datapath.sv
`default_nettype none
module wsl_datapath (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [wsl_pkg::DATA_W-1:0]       sample_value,
	input  wire logic [wsl_pkg::DATA_W-1:0]       sample_position,
	input  wire logic                             last_sample,
	input  wire logic                             cfg_valid,
	input  wire logic [63:0]                      flat_threshold,
	input  wire logic                             out_stall,
	input  wire wsl_pkg::cmd_t                    cmd,
	output wsl_pkg::sts_t                         sts,
	output logic                                  out_valid,
	output logic [wsl_pkg::DATA_W-1:0]            gradient,
	output logic                                  last_result,
	output logic                                  range_error
);

	localparam int W  = wsl_pkg::DATA_W;
	localparam int DW = wsl_pkg::DIFF_W;
	localparam int VW = wsl_pkg::DIV_W;

	logic [63:0]   thr_q;
	logic [W-1:0]  cur_v_q, cur_x_q, held_v_q, held_x_q;
	logic          cur_last_q, have_q;
	logic [W-1:0]  left_q, gr_q;
	logic          left_err_q, gerr_q;

	logic [W-1:0]  sqa_mag_q, sqb_mag_q;
	logic [63:0]   sqa_q, sqb_q;
	logic [DW-1:0] s_q;
	logic          neg_q;
	logic [63:0]   sum_q;
	logic          weighted_q, zero_q;
	logic [63:0]   mp_q;
	logic [DW-1:0] ms_q;
	logic [64:0]   pp_lo_q, pp_hi_q;
	logic [W-1:0]  res_q;

	logic          out_valid_q, out_last_q, out_err_q;
	logic [W-1:0]  out_grad_q;

	logic [DW-1:0] dv, dx, mag_dv, mag_dx;
	logic          dv_neg, dx_neg, dv_pos, dx_zero;
	logic [W-1:0]  op_a, op_b, mag_a, mag_b;
	logic [DW-1:0] s_sum, mag_s, s_adj;
	logic [63:0]   sum_sq;

	logic          div_start, div_busy;
	logic [VW-1:0] div_rem, div_num, div_den, div_quot;
	logic [wsl_pkg::CNT_W-1:0] div_iters;
	logic          sl_neg, out_free;

	assign dv      = {cur_v_q[W-1], cur_v_q} - {held_v_q[W-1], held_v_q};
	assign dx      = {cur_x_q[W-1], cur_x_q} - {held_x_q[W-1], held_x_q};
	assign dv_neg  = dv[DW-1];
	assign dx_neg  = dx[DW-1];
	assign dv_pos  = !dv_neg && (dv != '0);
	assign dx_zero = (dx == '0);
	assign mag_dv  = dv_neg ? (~dv + DW'(1)) : dv;
	assign mag_dx  = dx_neg ? (~dx + DW'(1)) : dx;
	assign sl_neg  = dv_neg != dx_neg;

	assign op_a  = cmd.second ? gr_q : left_q;
	assign op_b  = cmd.second ? '0 : gr_q;
	assign mag_a = op_a[W-1] ? (~op_a + W'(1)) : op_a;
	assign mag_b = op_b[W-1] ? (~op_b + W'(1)) : op_b;
	assign s_sum = {op_a[W-1], op_a} + {op_b[W-1], op_b};
	assign mag_s = s_q[DW-1] ? (~s_q + DW'(1)) : s_q;
	assign s_adj = s_q + DW'(s_q[DW-1]);
	assign sum_sq = sqa_q + sqb_q;

	assign div_start = cmd.sl_div_start || cmd.c_div_start;
	always_comb begin
		if (cmd.c_div_start) begin
			div_rem   = pp_hi_q[63:0] + 64'(pp_lo_q[64:32]);
			div_num   = {pp_lo_q[31:0], 32'b0};
			div_den   = sum_q;
			div_iters = wsl_pkg::CNT_W'(wsl_pkg::COMB_ITERS);
		end else begin
			div_rem   = '0;
			div_num   = {mag_dv, {(VW-DW){1'b0}}};
			div_den   = VW'(mag_dx);
			div_iters = wsl_pkg::CNT_W'(wsl_pkg::SLOPE_ITERS);
		end
	end

	wsl_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem),
		.dividend (div_num),
		.divisor  (div_den),
		.iters    (div_iters),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= '0;
			have_q <= 1'b0;
		end else begin
			if (cfg_valid)
				thr_q <= flat_threshold;
			if (cmd.accept && !have_q && !last_sample)
				have_q <= 1'b1;
			else if (cmd.clear)
				have_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cur_v_q    <= sample_value;
			cur_x_q    <= sample_position;
			cur_last_q <= last_sample;
			if (!have_q) begin
				held_v_q   <= sample_value;
				held_x_q   <= sample_position;
				left_q     <= '0;
				left_err_q <= 1'b0;
			end
		end
		if (cmd.commit) begin
			held_v_q   <= cur_v_q;
			held_x_q   <= cur_x_q;
			left_q     <= gr_q;
			left_err_q <= gerr_q;
		end
		if (cmd.sl_fin) begin
			if (dx_zero) begin
				gerr_q <= 1'b1;
				gr_q   <= dv_pos ? {1'b0, {(W-1){1'b1}}} :
					(dv_neg ? {1'b1, {(W-1){1'b0}}} : '0);
			end else begin
				gerr_q <= wsl_pkg::sat_hit(div_quot, sl_neg);
				gr_q   <= wsl_pkg::sat_mag(div_quot, sl_neg);
			end
		end
		if (cmd.c_sq) begin
			sqa_q     <= 64'(mag_a) * 64'(mag_a);
			sqb_q     <= 64'(mag_b) * 64'(mag_b);
			sqa_mag_q <= mag_a;
			sqb_mag_q <= mag_b;
			s_q       <= s_sum;
			neg_q     <= (op_a[W-1] != op_b[W-1]) != s_sum[DW-1];
		end
		if (cmd.c_cmp) begin
			sum_q      <= sum_sq;
			weighted_q <= sum_sq > thr_q;
			mp_q       <= 64'(sqa_mag_q) * 64'(sqb_mag_q);
			ms_q       <= mag_s;
			zero_q     <= (sqa_mag_q == '0) || (sqb_mag_q == '0) || (s_q == '0);
		end
		if (cmd.c_mul1)
			pp_lo_q <= 65'(mp_q[31:0]) * 65'(ms_q);
		if (cmd.c_mul2)
			pp_hi_q <= 65'(mp_q[63:32]) * 65'(ms_q);
		if (cmd.c_res) begin
			if (!weighted_q)
				res_q <= s_adj[DW-1:1];
			else if (zero_q)
				res_q <= '0;
			else
				res_q <= wsl_pkg::sat_mag(div_quot, neg_q);
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.out_kind)
				wsl_pkg::OUT_SINGLE: begin
					out_grad_q <= '0;
					out_last_q <= 1'b1;
					out_err_q  <= 1'b0;
				end
				wsl_pkg::OUT_LEFT: begin
					out_grad_q <= res_q;
					out_last_q <= 1'b0;
					out_err_q  <= left_err_q || gerr_q;
				end
				default: begin
					out_grad_q <= res_q;
					out_last_q <= 1'b1;
					out_err_q  <= gerr_q;
				end
			endcase
		end
	end

	assign sts.have      = have_q;
	assign sts.cur_last  = cur_last_q;
	assign sts.dx_zero   = dx_zero;
	assign sts.div_busy  = div_busy;
	assign sts.do_divide = weighted_q && !zero_q;
	assign sts.out_free  = out_free;

	assign out_valid   = out_valid_q;
	assign gradient    = out_grad_q;
	assign last_result = out_last_q;
	assign range_error = out_err_q;

endmodule
`default_nettype wire

FILE: hdl/wsl_ctrl.sv
`default_nettype none
module wsl_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          last_sample,
	input  wire wsl_pkg::sts_t sts,
	output logic               in_stall,
	output wsl_pkg::cmd_t      cmd
);

	wsl_pkg::state_t state_q, state_d;
	logic            second_q, second_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= wsl_pkg::ST_IDLE;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			second_q <= second_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		second_d     = second_q;
		cmd          = '0;
		cmd.second   = second_q;
		cmd.out_kind = wsl_pkg::OUT_SINGLE;
		in_stall     = (state_q != wsl_pkg::ST_IDLE);
		unique case (state_q)
			wsl_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (!sts.have)
						state_d = last_sample ? wsl_pkg::ST_SINGLE : wsl_pkg::ST_IDLE;
					else
						state_d = wsl_pkg::ST_SL_START;
				end
			end
			wsl_pkg::ST_SINGLE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = wsl_pkg::OUT_SINGLE;
					state_d      = wsl_pkg::ST_IDLE;
				end
			end
			wsl_pkg::ST_SL_START: begin
				if (sts.dx_zero)
					state_d = wsl_pkg::ST_SL_FIN;
				else begin
					cmd.sl_div_start = 1'b1;
					state_d          = wsl_pkg::ST_SL_WAIT;
				end
			end
			wsl_pkg::ST_SL_WAIT: begin
				if (!sts.div_busy)
					state_d = wsl_pkg::ST_SL_FIN;
			end
			wsl_pkg::ST_SL_FIN: begin
				cmd.sl_fin = 1'b1;
				state_d    = wsl_pkg::ST_C_SQ;
			end
			wsl_pkg::ST_C_SQ: begin
				cmd.c_sq = 1'b1;
				state_d  = wsl_pkg::ST_C_CMP;
			end
			wsl_pkg::ST_C_CMP: begin
				cmd.c_cmp = 1'b1;
				state_d   = wsl_pkg::ST_C_BRANCH;
			end
			wsl_pkg::ST_C_BRANCH: begin
				state_d = sts.do_divide ? wsl_pkg::ST_C_MUL1 : wsl_pkg::ST_C_RES;
			end
			wsl_pkg::ST_C_MUL1: begin
				cmd.c_mul1 = 1'b1;
				state_d    = wsl_pkg::ST_C_MUL2;
			end
			wsl_pkg::ST_C_MUL2: begin
				cmd.c_mul2 = 1'b1;
				state_d    = wsl_pkg::ST_C_DIV_START;
			end
			wsl_pkg::ST_C_DIV_START: begin
				cmd.c_div_start = 1'b1;
				state_d         = wsl_pkg::ST_C_DIV_WAIT;
			end
			wsl_pkg::ST_C_DIV_WAIT: begin
				if (!sts.div_busy)
					state_d = wsl_pkg::ST_C_RES;
			end
			wsl_pkg::ST_C_RES: begin
				cmd.c_res = 1'b1;
				state_d   = wsl_pkg::ST_EMIT;
			end
			wsl_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = second_q ? wsl_pkg::OUT_RIGHT : wsl_pkg::OUT_LEFT;
					if (!second_q && sts.cur_last) begin
						second_d = 1'b1;
						state_d  = wsl_pkg::ST_C_SQ;
					end else if (!second_q) begin
						cmd.commit = 1'b1;
						state_d    = wsl_pkg::ST_IDLE;
					end else begin
						cmd.clear = 1'b1;
						second_d  = 1'b0;
						state_d   = wsl_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = wsl_pkg::ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

FILE: hdl/weighted_slope_limiter.sv
`default_nettype none
// Weighted slope limiter. Samples (value, position, Q16.16) stream in. Each one
// gives the limited gradient of the sample before it, and a last sample
// flushes two results. One shared bit-serial divider does the work: a 49-step
// slope division and, when the weighted branch needs it, a 32-step weighting
// division per result. Equal positions skip the slope division. A last sample
// runs the weighting stage a second time for its own result. The first sample
// of a run is only stored, and a run of one sample gives a single zero result.
// Output stalls hold the controller until the output register is free. The
// input takes the next sample once all results of the current one sit in the
// output register. flat_threshold is to be written through cfg_valid/cfg_ready
// only while idle; the block itself does not enforce this.
module weighted_slope_limiter (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [wsl_pkg::DATA_W-1:0] sample_value,
	input  wire logic [wsl_pkg::DATA_W-1:0] sample_position,
	input  wire logic                       last_sample,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [wsl_pkg::DATA_W-1:0]      gradient,
	output logic                            last_result,
	output logic                            range_error,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [63:0]                flat_threshold
);

	wsl_pkg::cmd_t cmd;
	wsl_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	wsl_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.last_sample (last_sample),
		.sts         (sts),
		.in_stall    (in_stall),
		.cmd         (cmd)
	);

	wsl_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_value    (sample_value),
		.sample_position (sample_position),
		.last_sample     (last_sample),
		.cfg_valid       (cfg_valid),
		.flat_threshold  (flat_threshold),
		.out_stall       (out_stall),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (out_valid),
		.gradient        (gradient),
		.last_result     (last_result),
		.range_error     (range_error)
	);

endmodule
`default_nettype wire
